FILE: sv/fla_pkg.sv
// Shared types and constants of the free-list ID allocator.
package fla_pkg;

  localparam int unsigned PoolSize = 64;
  localparam int unsigned IdxW     = $clog2(PoolSize);
  localparam int unsigned CntW     = $clog2(PoolSize + 1);
  localparam int unsigned IdW      = 7;

  typedef enum logic [1:0] {
    OpAlloc   = 2'd0,
    OpRelease = 2'd1,
    OpCheck   = 2'd2,
    OpNone    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StDone    = 2'd0,
    StEmpty   = 2'd1,
    StInvalid = 2'd2,
    StUnused  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    InitS = 3'b001,
    IdleS = 3'b010,
    ExecS = 3'b100
  } state_e;

endpackage

FILE: sv/free_list_id_allocator.sv
// Free-list ID allocator: a ring of free IDs and a bitmap of allocated IDs in two RAMs.
//
// Request channel (in_valid_i/in_ready_o) carries operation_i and id_i:
// allocate pops the oldest free ID, release returns an allocated ID to the
// tail of the ring, check reports whether an ID is in range and free.
// Response channel (out_valid_o/out_ready_i) carries status_o, granted_id_o,
// is_free_o and free_count_o, exactly one response per request.
//
// In the accept cycle of an item the ring entry at the head and the bitmap
// entry of the ID are read; the registered read data returns in the next
// cycle, the execute cycle, where the result is formed and the RAMs are
// written back as the operation needs. The next item is accepted only in
// the cycle after the execute cycle ends, so items do not overlap. Since
// every write lands before the next read is issued, no forwarding is needed.
//
// After reset an initialization sweep over all 64 entries writes ring entry i
// with ID i and clears every bitmap entry; no item is accepted during the sweep.
// A response waits in an output register; while the receiver stalls, one
// further item may be accepted and holds in its execute cycle until the
// output register frees up.
module free_list_id_allocator
  import fla_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      operation_i,
  input  logic [IdW-1:0]  id_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [1:0]      status_o,
  output logic [IdxW-1:0] granted_id_o,
  output logic            is_free_o,
  output logic [CntW-1:0] free_count_o
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(PoolSize - 1);

  state_e          state_q, state_d;
  logic [IdxW-1:0] init_cnt_q, init_cnt_d;
  logic [IdxW-1:0] head_q, head_d;
  logic [IdxW-1:0] tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;
  op_e             op_q;
  logic [IdW-1:0]  id_q;

  logic            out_valid_q, out_valid_d;
  status_e         status_q, status_d;
  logic [IdxW-1:0] granted_q, granted_d;
  logic            is_free_q, is_free_d;
  logic [CntW-1:0] free_cnt_q;

  logic            accept;
  logic            out_free;
  logic            fire;
  logic            id_ok;
  logic [IdxW-1:0] tail_next;

  logic            ring_we, map_we;
  logic [IdxW-1:0] ring_waddr, map_waddr;
  logic [IdxW-1:0] ring_wdata;
  logic            map_wdata;
  logic [IdxW-1:0] ring_rdata;
  logic            map_rdata;
  logic            exec_ring_we, exec_map_we;
  logic [IdxW-1:0] exec_map_addr;
  logic            exec_map_data;

  assign in_ready_o = (state_q == IdleS);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign fire       = (state_q == ExecS) && out_free;
  assign id_ok      = (id_q < IdW'(PoolSize));
  assign tail_next  = (tail_q == LastIdx) ? '0 : tail_q + 1'b1;

  // Result and write-back of the item in its execute cycle.
  always_comb begin
    head_d        = head_q;
    tail_d        = tail_q;
    count_d       = count_q;
    status_d      = StDone;
    granted_d     = '0;
    is_free_d     = 1'b0;
    exec_ring_we  = 1'b0;
    exec_map_we   = 1'b0;
    exec_map_addr = id_q[IdxW-1:0];
    exec_map_data = 1'b0;
    unique case (op_q)
      OpAlloc: begin
        if (count_q == '0) begin
          status_d = StEmpty;
        end else begin
          granted_d     = ring_rdata;
          exec_map_we   = 1'b1;
          exec_map_addr = ring_rdata;
          exec_map_data = 1'b1;
          head_d        = (head_q == LastIdx) ? '0 : head_q + 1'b1;
          count_d       = count_q - 1'b1;
        end
      end
      OpRelease: begin
        if (!id_ok || !map_rdata) begin
          status_d = StInvalid;
        end else begin
          exec_map_we  = 1'b1;
          exec_ring_we = 1'b1;
          tail_d       = tail_next;
          count_d      = count_q + 1'b1;
        end
      end
      OpCheck: begin
        is_free_d = id_ok && !map_rdata;
      end
      default: begin
      end
    endcase
  end

  // The initialization sweep owns the write ports until it ends.
  always_comb begin
    if (state_q == InitS) begin
      ring_we    = 1'b1;
      ring_waddr = init_cnt_q;
      ring_wdata = init_cnt_q;
      map_we     = 1'b1;
      map_waddr  = init_cnt_q;
      map_wdata  = 1'b0;
    end else begin
      ring_we    = fire && exec_ring_we;
      ring_waddr = tail_next;
      ring_wdata = id_q[IdxW-1:0];
      map_we     = fire && exec_map_we;
      map_waddr  = exec_map_addr;
      map_wdata  = exec_map_data;
    end
  end

  always_comb begin
    state_d     = state_q;
    init_cnt_d  = init_cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      InitS: begin
        init_cnt_d = init_cnt_q + 1'b1;
        if (init_cnt_q == LastIdx) begin
          state_d = IdleS;
        end
      end
      IdleS: begin
        if (accept) begin
          state_d = ExecS;
        end
      end
      ExecS: begin
        if (out_free) begin
          state_d     = IdleS;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = InitS;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= InitS;
      init_cnt_q  <= '0;
      head_q      <= '0;
      tail_q      <= LastIdx;
      count_q     <= CntW'(PoolSize);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_cnt_q  <= init_cnt_d;
      out_valid_q <= out_valid_d;
      if (fire) begin
        head_q  <= head_d;
        tail_q  <= tail_d;
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= op_e'(operation_i);
      id_q <= id_i;
    end
    if (fire) begin
      status_q   <= status_d;
      granted_q  <= granted_d;
      is_free_q  <= is_free_d;
      free_cnt_q <= count_d;
    end
  end

  fla_ram #(
    .Width(IdxW),
    .Depth(PoolSize)
  ) u_ring_ram (
    .clk_i  (clk_i),
    .we_i   (ring_we),
    .waddr_i(ring_waddr),
    .wdata_i(ring_wdata),
    .re_i   (accept),
    .raddr_i(head_q),
    .rdata_o(ring_rdata)
  );

  fla_ram #(
    .Width(1),
    .Depth(PoolSize)
  ) u_map_ram (
    .clk_i  (clk_i),
    .we_i   (map_we),
    .waddr_i(map_waddr),
    .wdata_i(map_wdata),
    .re_i   (accept),
    .raddr_i(id_i[IdxW-1:0]),
    .rdata_o(map_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign granted_id_o = granted_q;
  assign is_free_o    = is_free_q;
  assign free_count_o = free_cnt_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(PoolSize))
    else $error("free count exceeds the pool size");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ExecS)
    else $error("accepted item did not enter its execute cycle");

  a_no_resp_in_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == InitS |-> !out_valid_o)
    else $error("response presented during the initialization sweep");

  a_empty_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StEmpty |-> granted_id_o == '0 && free_count_o == '0)
    else $error("failed allocate carries an ID or a nonzero free count");

  a_free_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_free_o |-> status_o == StDone && granted_id_o == '0)
    else $error("check response mixed with another result");

endmodule

FILE: sv/fla_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fla_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: tb/free_list_id_allocator_test.sv
// Self-checking testbench for the free-list ID allocator, with random request and response idling.
module free_list_id_allocator_test;
  import fla_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned BlockLen   = 110;
  localparam int unsigned NumBlocks  = 10;

  typedef struct packed {
    status_e         status;
    logic [IdxW-1:0] granted;
    logic            is_free;
    logic [CntW-1:0] count;
  } alloc_result_t;

  // Tracks the allocator state and the responses it should produce, in order.
  class alloc_scoreboard;
    logic [IdxW-1:0] ring [PoolSize];
    bit              used [PoolSize];
    int unsigned     head;
    int unsigned     tail;
    logic [CntW-1:0] nfree;
    alloc_result_t   awaited_results[$];
    int unsigned     errors;
    int unsigned     grants;
    int unsigned     empties;
    int unsigned     rejects;
    int unsigned     free_hits;
    int unsigned     responses;

    function new();
      for (int i = 0; i < PoolSize; i++) begin
        ring[i] = IdxW'(i);
        used[i] = 1'b0;
      end
      head = 0;
      tail = PoolSize - 1;
      nfree = CntW'(PoolSize);
    endfunction

    task report(string msg);
      if (errors < 40) begin
        $display("[%0t] mismatch: %s", $time, msg);
      end
      errors++;
    endtask

    // Applies one accepted request to the model and queues its response.
    function void note_request(op_e op, logic [IdW-1:0] id);
      alloc_result_t res;
      bit in_range;
      res = '{status: StDone, granted: '0, is_free: 1'b0, count: '0};
      in_range = id < PoolSize;
      case (op)
        OpAlloc: begin
          if (nfree == 0) begin
            res.status = StEmpty;
            empties++;
          end else begin
            res.granted = ring[head];
            used[ring[head]] = 1'b1;
            head = (head + 1 == PoolSize) ? 0 : head + 1;
            nfree--;
            grants++;
          end
        end
        OpRelease: begin
          if (!in_range || !used[id[IdxW-1:0]]) begin
            res.status = StInvalid;
            rejects++;
          end else begin
            used[id[IdxW-1:0]] = 1'b0;
            tail = (tail + 1 == PoolSize) ? 0 : tail + 1;
            ring[tail] = id[IdxW-1:0];
            nfree++;
          end
        end
        OpCheck: begin
          res.is_free = in_range && !used[id[IdxW-1:0]];
          if (res.is_free) free_hits++;
        end
        default: ;
      endcase
      res.count = nfree;
      awaited_results.push_back(res);
    endfunction

    task check_response(logic [1:0] st, logic [IdxW-1:0] g, logic f, logic [CntW-1:0] c);
      alloc_result_t want;
      responses++;
      if (awaited_results.size() == 0) begin
        report($sformatf("response with nothing pending (status %0d id %0d)", st, g));
      end else begin
        want = awaited_results.pop_front();
        if (st !== want.status)
          report($sformatf("status %0d, expected %0d", st, want.status));
        if (g !== want.granted)
          report($sformatf("granted_id %0d, expected %0d", g, want.granted));
        if (f !== want.is_free)
          report($sformatf("is_free %0b, expected %0b", f, want.is_free));
        if (c !== want.count)
          report($sformatf("free_count %0d, expected %0d", c, want.count));
      end
    endtask

    // Returns a random currently allocated ID, or -1 when no ID is allocated.
    function int pick_allocated();
      int held[$];
      for (int i = 0; i < PoolSize; i++) begin
        if (used[i]) held.push_back(i);
      end
      if (held.size() == 0) return -1;
      return held[$urandom_range(0, held.size() - 1)];
    endfunction
  endclass

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_ready_o;
  logic [1:0]      operation_i;
  logic [IdW-1:0]  id_i;
  logic            out_valid_o;
  logic            out_ready_i;
  logic [1:0]      status_o;
  logic [IdxW-1:0] granted_id_o;
  logic            is_free_o;
  logic [CntW-1:0] free_count_o;

  alloc_scoreboard sb;
  int unsigned     gap_max;
  int unsigned     stall_max;
  int unsigned     stall_left;
  int unsigned     cycle_count;
  int unsigned     sent;

  free_list_id_allocator DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .id_i         (id_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .granted_id_o (granted_id_o),
    .is_free_o    (is_free_o),
    .free_count_o (free_count_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Response side: ready drops for a random number of cycles before each item.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_response(status_o, granted_id_o, is_free_o, free_count_o);
      stall_left = $urandom_range(0, stall_max);
    end
  end

  task automatic send_request(op_e op, logic [IdW-1:0] id);
    int unsigned gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    operation_i <= op;
    id_i        <= id;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(op, id);
    sent++;
  endtask

  task automatic send_release_of_held();
    int pick;
    pick = sb.pick_allocated();
    if (pick < 0) send_request(OpRelease, IdW'($urandom_range(0, 127)));
    else send_request(OpRelease, IdW'(pick));
  endtask

  task automatic send_check();
    if ($urandom_range(0, 1) == 1) send_request(OpCheck, IdW'($urandom_range(0, 127)));
    else send_request(OpCheck, IdW'($urandom_range(0, PoolSize - 1)));
  endtask

  task automatic send_random(int unsigned alloc_pct, int unsigned release_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < alloc_pct) begin
      send_request(OpAlloc, IdW'($urandom_range(0, 127)));
    end else if (r < alloc_pct + release_pct) begin
      send_release_of_held();
    end else if (r < 92) begin
      send_check();
    end else begin
      send_request(op_e'($urandom_range(0, 3)), IdW'($urandom_range(0, 127)));
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    operation_i = OpAlloc;
    id_i        = '0;
    gap_max     = 3;
    stall_max   = 3;
    stall_left  = 0;
    cycle_count = 0;
    sent        = 0;
    sb = new();
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: range edges, unused code, invalid and double release.
    send_request(OpCheck, 7'd0);
    send_request(OpCheck, 7'd63);
    send_request(OpCheck, 7'd64);
    send_request(OpCheck, 7'd127);
    send_request(OpRelease, 7'd5);
    send_request(OpRelease, 7'd64);
    send_request(OpRelease, 7'd127);
    send_request(OpNone, 7'd127);
    send_request(OpNone, 7'd0);
    send_request(OpAlloc, 7'd127);
    send_request(OpAlloc, 7'd0);
    send_request(OpCheck, 7'd0);
    send_request(OpRelease, 7'd0);
    send_request(OpRelease, 7'd0);
    send_request(OpAlloc, 7'd85);
    send_request(OpRelease, 7'd1);
    send_request(OpRelease, 7'd2);
    send_request(OpCheck, 7'd1);
    send_request(OpAlloc, 7'd42);
    send_request(OpRelease, 7'd63);
    send_request(OpCheck, 7'd3);

    // Random blocks alternate between draining the pool, refilling it and a mix.
    for (int b = 0; b < NumBlocks; b++) begin
      if (b % 4 == 3) begin
        gap_max   = 0;
        stall_max = 0;
      end else begin
        gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 3;
        stall_max = ($urandom_range(0, 3) == 0) ? 0 : 3;
      end
      for (int i = 0; i < BlockLen; i++) begin
        case (b % 3)
          0:       send_random(80, 6);
          1:       send_random(15, 65);
          default: send_random(40, 35);
        endcase
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.awaited_results.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d requests, checked %0d responses in %0d cycles.",
             sent, sb.responses, cycle_count);
    $display("Grants %0d, empty-pool refusals %0d, rejected releases %0d, free checks %0d.",
             sb.grants, sb.empties, sb.rejects, sb.free_hits);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
